### rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared widths, token kinds, token record and character helpers for the
// C subset tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int NUMBER_BITS = 32;
   localparam int OFFSET_BITS = 32;
   localparam int LINE_BITS   = 16;
   localparam int LENGTH_BITS = 16;
   localparam int KIND_BITS   = 5;
   localparam int CODE_BITS   = 6;
   localparam int KW_CHARS    = 6;
   localparam int KW_BITS     = CODE_BITS * KW_CHARS;

   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FIFO_COUNT_BITS = $clog2(FIFO_DEPTH + 1);

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_EOF       = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_INT       = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_RETURN    = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_IF        = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_ELSE      = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_WHILE     = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_IDENT     = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER    = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN    = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN    = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE    = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE    = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_SEMI      = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_COMMA     = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_PLUS      = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_MINUS     = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_STAR      = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_SLASH     = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN    = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_EQ        = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_NE        = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_LT        = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_GT        = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_LE        = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_GE        = 5'd24;
   localparam logic [KIND_BITS-1:0] KIND_ERROR     = 5'd25;

   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_UNDERSCORE = "_";
   localparam logic [CODE_BITS-1:0] CODE_UNDERSCORE = 6'd62;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [NUMBER_BITS-1:0] value;
      logic                   overflow;
      logic [OFFSET_BITS-1:0] offset;
      logic [LENGTH_BITS-1:0] length;
      logic [LINE_BITS-1:0]   line;
      logic [LINE_BITS-1:0]   column;
      logic                   last;
   } token_type;

   // up to two tokens written into the result queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic has_room;
   } fifo_stat_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_ident_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || (c == 8'h09) || (c == CH_NEWLINE) || (c == 8'h0B) ||
             (c == 8'h0C) || (c == 8'h0D);
   endfunction

   // 6-bit packing code: digits, upper case, lower case, then everything else
   function automatic logic [CODE_BITS-1:0] char_code(input logic [7:0] c);
      logic [CODE_BITS-1:0] code;
      code = CODE_UNDERSCORE;
      if (is_digit(c)) begin
         code = CODE_BITS'(c - 8'h30);
      end else if ((c >= "A") && (c <= "Z")) begin
         code = CODE_BITS'(c - 8'h41 + 8'd10);
      end else if ((c >= "a") && (c <= "z")) begin
         code = CODE_BITS'(c - 8'h61 + 8'd36);
      end
      return code;
   endfunction

   localparam logic [KW_BITS-1:0] KW_INT =
      KW_BITS'({char_code("i"), char_code("n"), char_code("t")});
   localparam logic [KW_BITS-1:0] KW_RETURN =
      KW_BITS'({char_code("r"), char_code("e"), char_code("t"),
                char_code("u"), char_code("r"), char_code("n")});
   localparam logic [KW_BITS-1:0] KW_IF =
      KW_BITS'({char_code("i"), char_code("f")});
   localparam logic [KW_BITS-1:0] KW_ELSE =
      KW_BITS'({char_code("e"), char_code("l"), char_code("s"), char_code("e")});
   localparam logic [KW_BITS-1:0] KW_WHILE =
      KW_BITS'({char_code("w"), char_code("h"), char_code("i"),
                char_code("l"), char_code("e")});

endpackage

### rtl/core/cst_req_if.sv
// ----------------------------------------------------------------------------
// cst_req_if
// Source byte channel: one byte or an end marker per item.
// ----------------------------------------------------------------------------
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_mark;

   modport source (output valid, output char_in, output end_mark, input ready);
   modport sink   (input valid, input char_in, input end_mark, output ready);
endinterface

### rtl/core/cst_rsp_if.sv
// ----------------------------------------------------------------------------
// cst_rsp_if
// Token channel: one token per item.
// ----------------------------------------------------------------------------
interface cst_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [31:0] number_value;
   logic        number_overflow;
   logic [31:0] token_offset;
   logic [15:0] token_length;
   logic [15:0] token_line;
   logic [15:0] token_column;
   logic        last_of_run;

   modport source (output valid, output token_kind, output number_value,
                   output number_overflow, output token_offset, output token_length,
                   output token_line, output token_column, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input number_value,
                   input number_overflow, input token_offset, input token_length,
                   input token_line, input token_column, input last_of_run,
                   output ready);
endinterface

### rtl/core/cst_tok_fifo.sv
// ----------------------------------------------------------------------------
// cst_tok_fifo
// Small token queue: takes up to two tokens per cycle, gives one per cycle.
// ----------------------------------------------------------------------------
module cst_tok_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  cst_pkg::push_type      push,
   input  logic                   pop,
   output cst_pkg::token_type     head,
   output cst_pkg::fifo_stat_type stat
);
   import cst_pkg::*;

   token_type                  mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_COUNT_BITS-1:0] count_ff, count_in;
   logic [FIFO_PTR_BITS-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + FIFO_PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
   assign count_in  = count_ff + FIFO_COUNT_BITS'(push.count) - FIFO_COUNT_BITS'(pop);

   assign head           = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != '0);
   // room for a full pair of tokens
   assign stat.has_room  = (count_ff <= FIFO_COUNT_BITS'(FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule

### rtl/core/c_subset_tokenizer.sv
// ----------------------------------------------------------------------------
// c_subset_tokenizer
// Streaming lexer for a small C subset: bytes in, tokens out.
// ----------------------------------------------------------------------------
// Feed one source byte per item on req_bus, or an item with end_mark set to
// close the text. Tokens come out on rsp_bus in source order; each byte causes
// zero, one or two tokens, and the last token caused by an item carries
// last_of_run. The block takes one item per clock while the queue has room:
// a byte is registered, the lexer state and the tokens it ends are worked
// out from it combinationally, and the tokens go into a four-entry queue
// that drives rsp_bus. Input stalls only while that queue holds more than two
// tokens, so with rsp_bus ready and at most one token per byte on average the
// rate is one byte per cycle. Identifiers report an offset and a length, not
// their text; keywords are found from the packed codes of the first six
// characters. Numbers saturate at 2^32-1 and set number_overflow. Line and
// column saturate at 65535, the byte offset wraps. An end marker flushes any
// pending token and then gives EOF; a comment open at the end gives no token.
// ----------------------------------------------------------------------------
module c_subset_tokenizer (
   input logic       clock,
   input logic       reset,
   cst_req_if.sink   req_bus,
   cst_rsp_if.source rsp_bus
);
   import cst_pkg::*;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_ASSIGN,
      MODE_BANG,
      MODE_LESS,
      MODE_GREATER
   } mode_type;

   // input register
   logic                   in_valid_ff;
   logic [7:0]             char_ff;
   logic                   end_ff;

   // lexer state
   mode_type               mode_ff, mode_in;
   logic [KW_BITS-1:0]     kw_ff, kw_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LINE_BITS-1:0]   column_ff, column_in;
   logic [OFFSET_BITS-1:0] start_offset_ff, start_offset_in;
   logic [LINE_BITS-1:0]   start_line_ff, start_line_in;
   logic [LINE_BITS-1:0]   start_column_ff, start_column_in;

   logic                   go;
   logic                   req_take;
   fifo_stat_type          fifo_stat;
   token_type              head;
   push_type               push;

   // digit accumulation
   logic [NUMBER_BITS-1:0] acc_base;
   logic                   ovf_base;
   logic [NUMBER_BITS+3:0] acc_sum;
   logic                   sum_over;
   logic [NUMBER_BITS-1:0] acc_next;
   logic                   ovf_next;

   // tokens of this byte
   logic                   first_v, second_v;
   token_type              first_tok, second_tok, flush_tok;
   logic                   flush_v;
   logic [KIND_BITS-1:0]   ident_kind;
   logic [KIND_BITS-1:0]   single_kind;
   logic                   fall;

   assign go       = in_valid_ff && fifo_stat.has_room;
   assign req_take = req_bus.valid && req_bus.ready;
   // take nothing while reset is held
   assign req_bus.ready = !reset && (!in_valid_ff || go);

   // add one digit; hold at the maximum once saturated
   assign acc_base = (mode_ff == MODE_NUMBER) ? acc_ff : '0;
   assign ovf_base = (mode_ff == MODE_NUMBER) ? ovf_ff : 1'b0;
   assign acc_sum  = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) +
                     (NUMBER_BITS + 4)'(char_ff[3:0]);
   assign sum_over = (acc_sum[NUMBER_BITS+3:NUMBER_BITS] != 4'b0);
   assign acc_next = ovf_base ? acc_base : (sum_over ? '1 : acc_sum[NUMBER_BITS-1:0]);
   assign ovf_next = ovf_base || sum_over;

   // keyword match on the packed prefix and the full length
   always_comb begin
      ident_kind = KIND_IDENT;
      if ((len_ff == LENGTH_BITS'(3)) && (kw_ff == KW_INT)) begin
         ident_kind = KIND_INT;
      end else if ((len_ff == LENGTH_BITS'(6)) && (kw_ff == KW_RETURN)) begin
         ident_kind = KIND_RETURN;
      end else if ((len_ff == LENGTH_BITS'(2)) && (kw_ff == KW_IF)) begin
         ident_kind = KIND_IF;
      end else if ((len_ff == LENGTH_BITS'(4)) && (kw_ff == KW_ELSE)) begin
         ident_kind = KIND_ELSE;
      end else if ((len_ff == LENGTH_BITS'(5)) && (kw_ff == KW_WHILE)) begin
         ident_kind = KIND_WHILE;
      end
   end

   // token that the pending mode would give if closed now
   always_comb begin
      flush_tok        = '0;
      flush_tok.offset = start_offset_ff;
      flush_tok.length = len_ff;
      flush_tok.line   = start_line_ff;
      flush_tok.column = start_column_ff;
      flush_v          = 1'b1;
      unique case (mode_ff)
         MODE_IDENT:   flush_tok.kind = ident_kind;
         MODE_NUMBER: begin
            flush_tok.kind     = KIND_NUMBER;
            flush_tok.value    = acc_ff;
            flush_tok.overflow = ovf_ff;
         end
         MODE_SLASH:   flush_tok.kind = KIND_SLASH;
         MODE_ASSIGN:  flush_tok.kind = KIND_ASSIGN;
         MODE_BANG:    flush_tok.kind = KIND_ERROR;
         MODE_LESS:    flush_tok.kind = KIND_LT;
         MODE_GREATER: flush_tok.kind = KIND_GT;
         default:      flush_v        = 1'b0;
      endcase
   end

   always_comb begin
      unique case (char_ff)
         "(":     single_kind = KIND_LPAREN;
         ")":     single_kind = KIND_RPAREN;
         "{":     single_kind = KIND_LBRACE;
         "}":     single_kind = KIND_RBRACE;
         ";":     single_kind = KIND_SEMI;
         ",":     single_kind = KIND_COMMA;
         "+":     single_kind = KIND_PLUS;
         "-":     single_kind = KIND_MINUS;
         "*":     single_kind = KIND_STAR;
         default: single_kind = KIND_ERROR;
      endcase
   end

   // next lexer state and the tokens this byte finishes
   always_comb begin
      mode_in         = mode_ff;
      kw_in           = kw_ff;
      len_in          = len_ff;
      acc_in          = acc_ff;
      ovf_in          = ovf_ff;
      offset_in       = offset_ff;
      line_in         = line_ff;
      column_in       = column_ff;
      start_offset_in = start_offset_ff;
      start_line_in   = start_line_ff;
      start_column_in = start_column_ff;
      first_v         = 1'b0;
      second_v        = 1'b0;
      first_tok       = flush_tok;
      second_tok      = '0;
      fall            = 1'b0;

      if (end_ff) begin
         // flush, then EOF at the current position; counters hold
         first_v           = flush_v;
         second_v          = 1'b1;
         second_tok.kind   = KIND_EOF;
         second_tok.offset = offset_ff;
         second_tok.line   = line_ff;
         second_tok.column = column_ff;
         mode_in           = MODE_IDLE;
      end else begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_ident_char(char_ff)) begin
                  if (len_ff < LENGTH_BITS'(KW_CHARS)) begin
                     kw_in = {kw_ff[KW_BITS-CODE_BITS-1:0], char_code(char_ff)};
                  end
                  if (len_ff != '1) begin
                     len_in = len_ff + LENGTH_BITS'(1);
                  end
               end else begin
                  fall    = 1'b1;
                  first_v = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(char_ff)) begin
                  acc_in = acc_next;
                  ovf_in = ovf_next;
                  if (len_ff != '1) begin
                     len_in = len_ff + LENGTH_BITS'(1);
                  end
               end else begin
                  fall    = 1'b1;
                  first_v = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (char_ff == "/") begin
                  mode_in = MODE_COMMENT;
               end else begin
                  fall    = 1'b1;
                  first_v = 1'b1;
               end
            end
            MODE_ASSIGN, MODE_BANG, MODE_LESS, MODE_GREATER: begin
               if (char_ff == "=") begin
                  // two-character operator closes here
                  first_v          = 1'b1;
                  first_tok.length = LENGTH_BITS'(2);
                  len_in           = LENGTH_BITS'(2);
                  mode_in          = MODE_IDLE;
                  unique case (mode_ff)
                     MODE_ASSIGN: first_tok.kind = KIND_EQ;
                     MODE_BANG:   first_tok.kind = KIND_NE;
                     MODE_LESS:   first_tok.kind = KIND_LE;
                     default:     first_tok.kind = KIND_GE;
                  endcase
               end else begin
                  fall    = 1'b1;
                  first_v = 1'b1;
               end
            end
            MODE_COMMENT: begin
               fall = (char_ff == CH_NEWLINE);
            end
            default: begin
               fall = 1'b1;
            end
         endcase

         if (fall) begin
            mode_in = MODE_IDLE;
            if (!is_space(char_ff)) begin
               if (is_alpha(char_ff) || (char_ff == CH_UNDERSCORE) || is_digit(char_ff) ||
                   (char_ff == "/") || (char_ff == "=") || (char_ff == "!") ||
                   (char_ff == "<") || (char_ff == ">")) begin
                  // open a pending token at this byte
                  len_in          = LENGTH_BITS'(1);
                  start_offset_in = offset_ff;
                  start_line_in   = line_ff;
                  start_column_in = column_ff;
                  if (is_digit(char_ff)) begin
                     mode_in = MODE_NUMBER;
                     acc_in  = acc_next;
                     ovf_in  = ovf_next;
                  end else if (is_alpha(char_ff) || (char_ff == CH_UNDERSCORE)) begin
                     mode_in = MODE_IDENT;
                     kw_in   = KW_BITS'(char_code(char_ff));
                  end else if (char_ff == "/") begin
                     mode_in = MODE_SLASH;
                  end else if (char_ff == "=") begin
                     mode_in = MODE_ASSIGN;
                  end else if (char_ff == "!") begin
                     mode_in = MODE_BANG;
                  end else if (char_ff == "<") begin
                     mode_in = MODE_LESS;
                  end else begin
                     mode_in = MODE_GREATER;
                  end
               end else begin
                  second_v          = 1'b1;
                  second_tok.kind   = single_kind;
                  second_tok.offset = offset_ff;
                  second_tok.length = LENGTH_BITS'(1);
                  second_tok.line   = line_ff;
                  second_tok.column = column_ff;
               end
            end
         end

         // advance the position past this byte
         offset_in = offset_ff + OFFSET_BITS'(1);
         if (char_ff == CH_NEWLINE) begin
            column_in = LINE_BITS'(1);
            if (line_ff != '1) begin
               line_in = line_ff + LINE_BITS'(1);
            end
         end else if (column_ff != '1) begin
            column_in = column_ff + LINE_BITS'(1);
         end
      end
   end

   // pack the tokens front to back; the last one closes the run
   always_comb begin
      push             = '0;
      push.second      = second_tok;
      push.second.last = 1'b1;
      if (first_v) begin
         push.first      = first_tok;
         push.first.last = !second_v;
      end else begin
         push.first = push.second;
      end
      if (go) begin
         push.count = 2'(first_v) + 2'(second_v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         mode_ff         <= MODE_IDLE;
         kw_ff           <= '0;
         len_ff          <= '0;
         acc_ff          <= '0;
         ovf_ff          <= 1'b0;
         offset_ff       <= '0;
         line_ff         <= LINE_BITS'(1);
         column_ff       <= LINE_BITS'(1);
         start_offset_ff <= '0;
         start_line_ff   <= LINE_BITS'(1);
         start_column_ff <= LINE_BITS'(1);
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (go) begin
            in_valid_ff <= 1'b0;
         end
         if (go) begin
            mode_ff         <= mode_in;
            kw_ff           <= kw_in;
            len_ff          <= len_in;
            acc_ff          <= acc_in;
            ovf_ff          <= ovf_in;
            offset_ff       <= offset_in;
            line_ff         <= line_in;
            column_ff       <= column_in;
            start_offset_ff <= start_offset_in;
            start_line_ff   <= start_line_in;
            start_column_ff <= start_column_in;
         end
      end
   end

   // hold the byte until the lexer takes it
   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff <= req_bus.char_in;
         end_ff  <= req_bus.end_mark;
      end
   end

   cst_tok_fifo u_tok_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (rsp_bus.valid && rsp_bus.ready),
      .head  (head),
      .stat  (fifo_stat)
   );

   assign rsp_bus.valid           = fifo_stat.not_empty;
   assign rsp_bus.token_kind      = head.kind;
   assign rsp_bus.number_value    = head.value;
   assign rsp_bus.number_overflow = head.overflow;
   assign rsp_bus.token_offset    = head.offset;
   assign rsp_bus.token_length    = head.length;
   assign rsp_bus.token_line      = head.line;
   assign rsp_bus.token_column    = head.column;
   assign rsp_bus.last_of_run     = head.last;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the C subset tokenizer. Source bytes are sent as
// items on req_bus; an in-bench lexer predicts every token and each token on
// rsp_bus is compared with the oldest prediction, field by field. Directed
// items cover the edge cases; random well-formed text plus noise covers the
// rest, with random sender gaps, receiver stalls and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cst_pkg::*;

   localparam int IDLE_LIMIT   = 5000;  // cycles with no item accepted on either side
   localparam int TAIL_CYCLES  = 20;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 1000;
   localparam logic [7:0] NL   = 8'h0A;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_SLASH, SCAN_COMMENT,
      SCAN_ASSIGN, SCAN_BANG, SCAN_LESS, SCAN_GREATER
   } scan_mode_type;

   logic clock = 1'b0;
   logic reset;

   cst_req_if req_bus ();
   cst_rsp_if rsp_bus ();

   c_subset_tokenizer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // text tables for the lexer model and the stimulus; the keyword text serves both
   string      keyword_text [5] = '{"int", "return", "if", "else", "while"};
   logic [4:0] keyword_kind [5] = '{KIND_INT, KIND_RETURN, KIND_IF, KIND_ELSE, KIND_WHILE};
   string      punct_text [18] = '{"(", ")", "{", "}", ";", ",", "+", "-", "*", "/",
                                   "=", "==", "!=", "<", ">", "<=", ">=", "!"};
   byte unsigned blank_bytes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   // ---------------------------------------------------------------------------
   // Lexer model state, starting from the reset state
   // ---------------------------------------------------------------------------
   scan_mode_type            scan_mode  = SCAN_IDLE;
   logic [39:0]              word_codes = '0;
   logic [LENGTH_BITS-1:0]   run_len    = '0;
   logic [NUMBER_BITS-1:0]   num_acc    = '0;
   logic                     num_sat    = 1'b0;
   logic [OFFSET_BITS-1:0]   pos_offset = '0;
   logic [LINE_BITS-1:0]     pos_line   = 1;
   logic [LINE_BITS-1:0]     pos_col    = 1;
   logic [OFFSET_BITS-1:0]   tok_offset = '0;
   logic [LINE_BITS-1:0]     tok_line   = 1;
   logic [LINE_BITS-1:0]     tok_col    = 1;

   token_type step_tokens [$];      // tokens caused by the byte being modeled
   token_type expected_tokens [$];  // tokens still owed by the block

   int unsigned errors          = 0;
   int unsigned items_sent      = 0;
   int unsigned tokens_checked  = 0;
   int unsigned idle_cycles     = 0;
   logic [31:0] kinds_seen      = '0;

   bit          pace_sender      = 1'b1;
   int unsigned burst_left       = 0;
   bit          hold_off_request = 1'b0;
   int unsigned hold_off_len     = 0;

   function automatic logic is_digit_ch(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter_ch(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_word_ch(input logic [7:0] c);
      return is_letter_ch(c) || is_digit_ch(c) || (c == "_");
   endfunction

   function automatic logic is_blank_ch(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   // 6-bit code: digits 0..9, upper case 10..35, lower case 36..61, rest 62
   function automatic logic [5:0] code_of(input logic [7:0] c);
      if (is_digit_ch(c)) return 6'(c - 8'd48);
      if ((c >= "A") && (c <= "Z")) return 6'(c - 8'd55);
      if ((c >= "a") && (c <= "z")) return 6'(c - 8'd61);
      return 6'd62;
   endfunction

   // classify a finished word by its packed first characters and its length
   function automatic logic [4:0] word_kind();
      logic [39:0] packed_text;
      for (int k = 0; k < 5; k++) begin
         packed_text = '0;
         for (int i = 0; i < keyword_text[k].len(); i++) begin
            packed_text = {packed_text[33:0], code_of(keyword_text[k][i])};
         end
         if ((run_len == keyword_text[k].len()) && (packed_text == word_codes)) begin
            return keyword_kind[k];
         end
      end
      return KIND_IDENT;
   endfunction

   function automatic void push_token(input logic [4:0] kind, input logic [31:0] value,
                                      input logic ovf, input logic [31:0] off,
                                      input logic [15:0] len, input logic [15:0] row,
                                      input logic [15:0] col);
      token_type t;
      t.kind     = kind;
      t.value    = value;
      t.overflow = ovf;
      t.offset   = off;
      t.length   = len;
      t.line     = row;
      t.column   = col;
      t.last     = 1'b0;
      step_tokens.push_back(t);
   endfunction

   // emit whatever token is pending and drop back to idle
   function automatic void flush_pending();
      case (scan_mode)
         SCAN_WORD:    push_token(word_kind(), 0, 0, tok_offset, run_len, tok_line, tok_col);
         SCAN_NUMBER:  push_token(KIND_NUMBER, num_acc, num_sat, tok_offset, run_len,
                                  tok_line, tok_col);
         SCAN_SLASH:   push_token(KIND_SLASH, 0, 0, tok_offset, run_len, tok_line, tok_col);
         SCAN_ASSIGN:  push_token(KIND_ASSIGN, 0, 0, tok_offset, run_len, tok_line, tok_col);
         SCAN_BANG:    push_token(KIND_ERROR, 0, 0, tok_offset, run_len, tok_line, tok_col);
         SCAN_LESS:    push_token(KIND_LT, 0, 0, tok_offset, run_len, tok_line, tok_col);
         SCAN_GREATER: push_token(KIND_GT, 0, 0, tok_offset, run_len, tok_line, tok_col);
         default: begin
         end
      endcase
      scan_mode = SCAN_IDLE;
   endfunction

   function automatic void start_pending(input scan_mode_type mode);
      scan_mode  = mode;
      run_len    = 1;
      tok_offset = pos_offset;
      tok_line   = pos_line;
      tok_col    = pos_col;
   endfunction

   // saturate at 2^32-1 and hold there once the flag is set
   function automatic void add_digit(input logic [7:0] c);
      longint unsigned d;
      d = longint'(c) - 48;
      if (!num_sat) begin
         if (longint'(num_acc) > (64'hFFFF_FFFF - d) / 10) begin
            num_acc = '1;
            num_sat = 1'b1;
         end else begin
            num_acc = 32'(longint'(num_acc) * 10 + d);
         end
      end
   endfunction

   function automatic void grow_run();
      if (run_len != '1) run_len++;
   endfunction

   // offset wraps, line and column saturate
   function automatic void advance_position(input logic [7:0] c);
      pos_offset++;
      if (c == NL) begin
         if (pos_line != '1) pos_line++;
         pos_col = 1;
      end else if (pos_col != '1) begin
         pos_col++;
      end
   endfunction

   // model one accepted item and queue the tokens it causes
   function automatic void predict_item(input logic [7:0] c, input logic mark);
      logic [4:0] kind;
      bit         taken;
      token_type  t;
      taken = 1'b0;
      step_tokens.delete();
      if (mark) begin
         flush_pending();
         push_token(KIND_EOF, 0, 0, pos_offset, 0, pos_line, pos_col);
      end else begin
         case (scan_mode)
            SCAN_WORD: begin
               if (is_word_ch(c)) begin
                  if (run_len < 6) word_codes = {word_codes[33:0], code_of(c)};
                  grow_run();
                  taken = 1'b1;
               end else begin
                  flush_pending();
               end
            end
            SCAN_NUMBER: begin
               if (is_digit_ch(c)) begin
                  add_digit(c);
                  grow_run();
                  taken = 1'b1;
               end else begin
                  flush_pending();
               end
            end
            SCAN_SLASH: begin
               if (c == "/") begin
                  scan_mode = SCAN_COMMENT;
                  taken     = 1'b1;
               end else begin
                  flush_pending();
               end
            end
            SCAN_ASSIGN, SCAN_BANG, SCAN_LESS, SCAN_GREATER: begin
               if (c == "=") begin
                  case (scan_mode)
                     SCAN_ASSIGN: kind = KIND_EQ;
                     SCAN_BANG:   kind = KIND_NE;
                     SCAN_LESS:   kind = KIND_LE;
                     default:     kind = KIND_GE;
                  endcase
                  run_len = 2;
                  push_token(kind, 0, 0, tok_offset, run_len, tok_line, tok_col);
                  scan_mode = SCAN_IDLE;
                  taken     = 1'b1;
               end else begin
                  flush_pending();
               end
            end
            SCAN_COMMENT: begin
               if (c != NL) taken = 1'b1;
               else scan_mode = SCAN_IDLE;
            end
            default: scan_mode = SCAN_IDLE;
         endcase

         // a non-blank byte not absorbed by the pending token starts a new one
         if (!taken && !is_blank_ch(c)) begin
            if (is_letter_ch(c) || (c == "_")) begin
               start_pending(SCAN_WORD);
               word_codes = 40'(code_of(c));
            end else if (is_digit_ch(c)) begin
               start_pending(SCAN_NUMBER);
               num_acc = '0;
               num_sat = 1'b0;
               add_digit(c);
            end else if (c == "/") begin
               start_pending(SCAN_SLASH);
            end else if (c == "=") begin
               start_pending(SCAN_ASSIGN);
            end else if (c == "!") begin
               start_pending(SCAN_BANG);
            end else if (c == "<") begin
               start_pending(SCAN_LESS);
            end else if (c == ">") begin
               start_pending(SCAN_GREATER);
            end else begin
               case (c)
                  "(":     kind = KIND_LPAREN;
                  ")":     kind = KIND_RPAREN;
                  "{":     kind = KIND_LBRACE;
                  "}":     kind = KIND_RBRACE;
                  ";":     kind = KIND_SEMI;
                  ",":     kind = KIND_COMMA;
                  "+":     kind = KIND_PLUS;
                  "-":     kind = KIND_MINUS;
                  "*":     kind = KIND_STAR;
                  default: kind = KIND_ERROR;
               endcase
               push_token(kind, 0, 0, pos_offset, 1, pos_line, pos_col);
            end
         end
         advance_position(c);
      end

      // flag the final token of this item
      if (step_tokens.size() != 0) begin
         t      = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.push_back(t);
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: model accepted bytes, check accepted tokens, watch for a hang
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      token_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_item(req_bus.char_in, req_bus.end_mark);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            tokens_checked++;
            kinds_seen[rsp_bus.token_kind] = 1'b1;
            if (expected_tokens.size() == 0) begin
               $display("%0t: token kind %0d at offset %0d arrived with none expected",
                        $time, rsp_bus.token_kind, rsp_bus.token_offset);
               errors++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", want.kind, rsp_bus.token_kind);
               check_field("number_value", want.value, rsp_bus.number_value);
               check_field("number_overflow", want.overflow, rsp_bus.number_overflow);
               check_field("token_offset", want.offset, rsp_bus.token_offset);
               check_field("token_length", want.length, rsp_bus.token_length);
               check_field("token_line", want.line, rsp_bus.token_line);
               check_field("token_column", want.column, rsp_bus.token_column);
               check_field("last_of_run", want.last, rsp_bus.last_of_run);
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles, %0d tokens outstanding",
                     $time, IDLE_LIMIT, expected_tokens.size());
            $display("c_subset_tokenizer: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: stall on shifting segments, or hold off on request
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned seg_left;
      int unsigned seg_style;
      int unsigned tick;
      seg_left  = 0;
      seg_style = 0;
      tick      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            // hold ready low for a long stretch so the token queue fills
            rsp_bus.ready <= 1'b0;
            repeat (hold_off_len) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_style = $urandom_range(0, 3);
               seg_left  = $urandom_range(16, 96);
            end
            seg_left--;
            tick++;
            case (seg_style)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ((tick % 5) > 1);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------

   // offer one item at the falling edge and hold it until accepted
   task automatic send_byte(input logic [7:0] c, input logic mark);
      int unsigned gap;
      if (pace_sender) begin
         if (burst_left == 0) begin
            // drop valid for a random gap between bursts; often no gap at all
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
      end
      req_bus.valid    <= 1'b1;
      req_bus.char_in  <= c;
      req_bus.end_mark <= mark;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] random_word_char();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(48, 57));
         1:       return 8'($urandom_range(65, 90));
         2:       return "_";
         default: return 8'($urandom_range(97, 122));
      endcase
   endfunction

   // pause the sender until every owed token has come back
   task automatic wait_for_tokens();
      req_bus.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // byte extremes, lone bang, flush by end marker, repeated end marker
   task automatic test_edge_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("!x");
      send_end();
      send_end();
   endtask

   // keyword, two-char operators, saturating number, lone slash before the end
   task automatic test_keywords_and_limits();
      send_text("while>=b!=4294967296/");
      send_end();
   endtask

   // newline position update, then a comment left open at the end
   task automatic test_comment_at_end();
      send_text("\n//c");
      send_end();
   endtask

   // receiver holds off while the sender keeps offering bytes, every second one giving two tokens
   task automatic test_backpressure();
      hold_off_len     = HOLD_CYCLES;
      hold_off_request = 1'b1;
      pace_sender      = 1'b0;
      repeat (20) send_text("a(");
      pace_sender = 1'b1;
   endtask

   // mostly well-formed lexemes with random content, some noise and end markers
   task automatic test_random_text();
      int unsigned first_item;
      int unsigned pick;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            send_text(keyword_text[$urandom_range(0, 4)]);
            // a keyword with a tail is a plain identifier
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 4)) send_byte(random_word_char(), 1'b0);
            end
         end else if (pick < 28) begin
            send_byte(($urandom_range(0, 4) == 0) ? 8'("_") : 8'($urandom_range(97, 122)),
                      1'b0);
            repeat ($urandom_range(0, ($urandom_range(0, 9) == 0) ? 20 : 6)) begin
               send_byte(random_word_char(), 1'b0);
            end
         end else if (pick < 42) begin
            case ($urandom_range(0, 9))
               0:       send_text("4294967295");
               1:       send_text("4294967296");
               2:       send_text("000123456789012");
               default: repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(48, 57)), 1'b0);
            endcase
         end else if (pick < 72) begin
            send_text(punct_text[$urandom_range(0, 17)]);
         end else if (pick < 80) begin
            send_byte(blank_bytes[$urandom_range(0, 5)], 1'b0);
         end else if (pick < 86) begin
            send_text("//");
            repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(NL, 1'b0);
         end else if (pick < 97) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            send_end();
         end
         // separate lexemes only sometimes so tokens also end on each other
         case ($urandom_range(0, 3))
            0:       send_byte(" ", 1'b0);
            1:       send_byte(NL, 1'b0);
            default: begin
            end
         endcase
      end
      send_end();
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.char_in  = 8'h00;
      req_bus.end_mark = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_edge_bytes();
      wait_for_tokens();
      test_keywords_and_limits();
      wait_for_tokens();
      test_comment_at_end();
      wait_for_tokens();
      test_backpressure();
      wait_for_tokens();
      test_random_text();
      wait_for_tokens();

      // let any stray token show up before closing
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tokenizer run: %0d items sent, %0d tokens checked, %0d of 26 token kinds seen",
               items_sent, tokens_checked, $countones(kinds_seen[25:0]));
      $display("covered edge bytes, comments, number saturation, long output hold-off");
      if (errors == 0) begin
         $display("c_subset_tokenizer: match");
      end else begin
         $display("c_subset_tokenizer: mismatch");
      end
      $finish;
   end

endmodule

### c_subset_tokenizer.f
rtl/core/cst_pkg.sv
rtl/core/cst_req_if.sv
rtl/core/cst_rsp_if.sv
rtl/core/cst_tok_fifo.sv
rtl/core/c_subset_tokenizer.sv
dv/tb_top.sv
